// ===== sv/pct_pkg.sv =====
// Package for the pausable countdown timer: request and register codes,
// run-state encoding, reset values and the constant divide by 1000.
// No dependencies.
package pct_pkg;

  // Field widths
  localparam int unsigned SecW   = 17;
  localparam int unsigned MsW    = 32;
  localparam int unsigned EpochW = 40;
  localparam int unsigned DlW    = 41;
  localparam int unsigned CntW   = 8;
  localparam int unsigned ReqW   = 3;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = 40;

  // Request codes
  typedef enum logic [ReqW-1:0] {
    REQ_TOGGLE     = 3'd0,
    REQ_ADD_MIN    = 3'd1,
    REQ_SUB_MIN    = 3'd2,
    REQ_TICK       = 3'd3,
    REQ_RESET      = 3'd4,
    REQ_CLEAR_FLAG = 3'd5
  } req_e;

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CFG_DEFAULT_SEC = 2'd0,
    CFG_MAX_SEC     = 2'd1,
    CFG_MIN_SEC     = 2'd2,
    CFG_EPOCH_FLOOR = 2'd3
  } cfg_idx_e;

  // Session state, one-hot
  typedef enum logic [3:0] {
    ST_IDLE     = 4'b0001,
    ST_RUNNING  = 4'b0010,
    ST_PAUSED   = 4'b0100,
    ST_FINISHED = 4'b1000
  } run_e;

  // Run-state codes on the result port
  localparam logic [1:0] RS_IDLE     = 2'd0;
  localparam logic [1:0] RS_RUNNING  = 2'd1;
  localparam logic [1:0] RS_PAUSED   = 2'd2;
  localparam logic [1:0] RS_FINISHED = 2'd3;

  // Register reset values
  localparam logic [SecW-1:0]   DefaultSecRst = 17'd1500;
  localparam logic [SecW-1:0]   MaxSecRst     = 17'd5400;
  localparam logic [SecW-1:0]   MinSecRst     = 17'd60;
  localparam logic [EpochW-1:0] EpochFloorRst = 40'd1700000000;

  localparam logic [SecW-1:0] SecPerMin = 17'd60;

  // Exact floor(x / 1000) for any 32-bit x: (x * DivMul) >> DivShift
  localparam int unsigned DivMulW  = 29;
  localparam int unsigned DivShift = 38;
  localparam logic [DivMulW-1:0] DivMul = 29'd274877907;
  localparam int unsigned ProdW = MsW + DivMulW;
  localparam int unsigned StepW = ProdW - DivShift;

  // Encode the one-hot state for the result port
  function automatic logic [1:0] run_code(run_e st);
    logic [1:0] code;
    case (st)
      ST_IDLE:     code = RS_IDLE;
      ST_RUNNING:  code = RS_RUNNING;
      ST_PAUSED:   code = RS_PAUSED;
      ST_FINISHED: code = RS_FINISHED;
      default:     code = RS_IDLE;
    endcase
    return code;
  endfunction

endpackage

// ===== sv/pausable_countdown_timer.sv =====
// Pausable countdown session timer: input register, one pass of session
// logic, result register. Depends on pct_pkg.
//
// Channel  | Direction | Handshake                  | Beat
// ---------+-----------+----------------------------+--------------------------------
// in       | sink      | in_valid_i / in_stall_o    | req_type, now_ms, now_epoch
// out      | source    | out_valid_o / out_stall_i  | run_state, remaining, total,
//          |           |                            | completed_count, tick_flag
// cfg      | sink      | cfg_valid_i / cfg_ready_o  | cfg_index_i, cfg_data_i
//
// One item per cycle while out_stall_i is low; input register, then result register.
// The longest path is the millisecond elapsed subtract feeding the reciprocal
// multiply for the divide by 1000, then the compare against remaining.
// Reset puts the session idle with the reset register values; cfg is always ready.
// A stalled output holds its beat and stalls the input only when the input
// register is also full.
module pausable_countdown_timer (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // input channel
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [pct_pkg::ReqW-1:0]         req_type_i,
  input  logic [pct_pkg::MsW-1:0]          now_ms_i,
  input  logic [pct_pkg::EpochW-1:0]       now_epoch_i,
  // result channel
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [1:0]                       run_state_o,
  output logic [pct_pkg::SecW-1:0]         remaining_seconds_o,
  output logic [pct_pkg::SecW-1:0]         total_seconds_o,
  output logic [pct_pkg::CntW-1:0]         completed_count_o,
  output logic                             tick_flag_o,
  // configuration write channel
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [pct_pkg::CfgIdxW-1:0]      cfg_index_i,
  input  logic [pct_pkg::CfgDataW-1:0]     cfg_data_i
);

  // Configuration registers
  logic [pct_pkg::SecW-1:0]   default_sec_q, max_sec_q, min_sec_q;
  logic [pct_pkg::EpochW-1:0] epoch_floor_q;

  // Input stage
  logic                       in_vld_q;
  logic [pct_pkg::ReqW-1:0]   req_q;
  logic [pct_pkg::MsW-1:0]    now_ms_q;
  logic [pct_pkg::EpochW-1:0] now_epoch_q;

  // Session state
  pct_pkg::run_e              run_q, run_d;
  logic [pct_pkg::SecW-1:0]   total_q, total_d;
  logic [pct_pkg::SecW-1:0]   remaining_q, remaining_d;
  logic [pct_pkg::MsW-1:0]    last_ms_q, last_ms_d;
  logic [pct_pkg::CntW-1:0]   completed_q, completed_d;
  logic                       flag_q, flag_d;
  logic [pct_pkg::DlW-1:0]    deadline_q, deadline_d;
  logic                       flag_out;

  // Result stage
  logic                       out_vld_q;
  logic [1:0]                 out_run_q;
  logic [pct_pkg::SecW-1:0]   out_rem_q, out_tot_q;
  logic [pct_pkg::CntW-1:0]   out_cnt_q;
  logic                       out_flag_q;

  logic advance, fire, in_take;

  // Datapath terms
  logic [pct_pkg::MsW-1:0]    elapsed;
  logic [pct_pkg::ProdW-1:0]  prod;
  logic [pct_pkg::StepW-1:0]  step;
  logic                       epoch_ok, before_dl;
  logic [pct_pkg::DlW-1:0]    dl_rem, dl_arm;
  logic [pct_pkg::SecW:0]     tot_add, rem_add;
  logic                       add_ok, sub_ok;
  logic [pct_pkg::SecW-1:0]   tot_sub, rem_base;

  // Handshake control
  assign advance     = !out_vld_q || !out_stall_i;
  assign fire        = in_vld_q && advance;
  assign in_stall_o  = in_vld_q && !advance;
  assign in_take     = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      default_sec_q <= pct_pkg::DefaultSecRst;
      max_sec_q     <= pct_pkg::MaxSecRst;
      min_sec_q     <= pct_pkg::MinSecRst;
      epoch_floor_q <= pct_pkg::EpochFloorRst;
    end else if (cfg_valid_i) begin
      case (pct_pkg::cfg_idx_e'(cfg_index_i))
        pct_pkg::CFG_DEFAULT_SEC: default_sec_q <= cfg_data_i[pct_pkg::SecW-1:0];
        pct_pkg::CFG_MAX_SEC:     max_sec_q     <= cfg_data_i[pct_pkg::SecW-1:0];
        pct_pkg::CFG_MIN_SEC:     min_sec_q     <= cfg_data_i[pct_pkg::SecW-1:0];
        pct_pkg::CFG_EPOCH_FLOOR: epoch_floor_q <= cfg_data_i[pct_pkg::EpochW-1:0];
        default: ;
      endcase
    end
  end

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      req_q       <= req_type_i;
      now_ms_q    <= now_ms_i;
      now_epoch_q <= now_epoch_i;
    end
  end

  // Elapsed whole seconds on the millisecond counter, wrap taken modulo 2^32
  assign elapsed = now_ms_q - last_ms_q;
  assign prod    = {{pct_pkg::DivMulW{1'b0}}, elapsed}
                 * {{pct_pkg::MsW{1'b0}}, pct_pkg::DivMul};
  assign step    = prod[pct_pkg::ProdW-1:pct_pkg::DivShift];

  // Wall-clock checks against the armed deadline
  assign epoch_ok  = (now_epoch_q > epoch_floor_q) && (deadline_q > {1'b0, epoch_floor_q});
  assign before_dl = {1'b0, now_epoch_q} < deadline_q;
  assign dl_rem    = deadline_q - {1'b0, now_epoch_q};
  assign dl_arm    = {1'b0, now_epoch_q}
                   + {{(pct_pkg::DlW-pct_pkg::SecW){1'b0}}, remaining_q};
  // Past the deadline the remaining time counts as zero
  assign rem_base  = epoch_ok ? '0 : remaining_q;

  // Minute adjust terms
  assign tot_add = {1'b0, total_q} + {1'b0, pct_pkg::SecPerMin};
  assign rem_add = {1'b0, remaining_q} + {1'b0, pct_pkg::SecPerMin};
  assign add_ok  = !(tot_add > {1'b0, max_sec_q}) && !tot_add[pct_pkg::SecW];
  assign sub_ok  = !(total_q <= min_sec_q) && !(total_q < pct_pkg::SecPerMin);
  assign tot_sub = total_q - pct_pkg::SecPerMin;

  // Session update for the item in the input register
  always_comb begin
    run_d       = run_q;
    total_d     = total_q;
    remaining_d = remaining_q;
    last_ms_d   = last_ms_q;
    completed_d = completed_q;
    flag_out    = flag_q;
    deadline_d  = deadline_q;
    case (pct_pkg::req_e'(req_q))
      pct_pkg::REQ_TOGGLE: begin
        if (run_q == pct_pkg::ST_IDLE || run_q == pct_pkg::ST_PAUSED) begin
          run_d      = pct_pkg::ST_RUNNING;
          last_ms_d  = now_ms_q;
          deadline_d = dl_arm;
        end else if (run_q == pct_pkg::ST_RUNNING) begin
          run_d = pct_pkg::ST_PAUSED;
        end else begin
          run_d       = pct_pkg::ST_IDLE;
          total_d     = default_sec_q;
          remaining_d = default_sec_q;
          last_ms_d   = '0;
        end
      end
      pct_pkg::REQ_ADD_MIN: begin
        if (add_ok) begin
          total_d = tot_add[pct_pkg::SecW-1:0];
          if (run_q == pct_pkg::ST_FINISHED) begin
            run_d       = pct_pkg::ST_IDLE;
            remaining_d = tot_add[pct_pkg::SecW-1:0];
          end else if (rem_add <= tot_add) begin
            remaining_d = rem_add[pct_pkg::SecW-1:0];
          end
        end
      end
      pct_pkg::REQ_SUB_MIN: begin
        if (sub_ok) begin
          total_d = tot_sub;
          if (remaining_q > pct_pkg::SecPerMin) begin
            remaining_d = remaining_q - pct_pkg::SecPerMin;
          end else begin
            remaining_d = tot_sub;
            run_d       = pct_pkg::ST_IDLE;
          end
        end
      end
      pct_pkg::REQ_TICK: begin
        if (run_q == pct_pkg::ST_RUNNING) begin
          if (epoch_ok && before_dl) begin
            // Count down by the trusted wall clock
            if (dl_rem < {{(pct_pkg::DlW-pct_pkg::SecW){1'b0}}, remaining_q}) begin
              remaining_d = dl_rem[pct_pkg::SecW-1:0];
              flag_out    = 1'b1;
            end
          end else begin
            // Count down by elapsed whole seconds
            last_ms_d = now_ms_q;
            flag_out  = 1'b1;
            if ({{(pct_pkg::StepW-pct_pkg::SecW){1'b0}}, rem_base} > step) begin
              remaining_d = rem_base - step[pct_pkg::SecW-1:0];
            end else begin
              remaining_d = '0;
              run_d       = pct_pkg::ST_FINISHED;
              completed_d = completed_q + 8'd1;
            end
          end
        end
      end
      pct_pkg::REQ_RESET: begin
        run_d       = pct_pkg::ST_IDLE;
        total_d     = default_sec_q;
        remaining_d = default_sec_q;
        last_ms_d   = '0;
      end
      default: ;
    endcase
    // Drop the flag after reporting it on a clear request
    flag_d = (pct_pkg::req_e'(req_q) == pct_pkg::REQ_CLEAR_FLAG) ? 1'b0 : flag_out;
  end

  // Session state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q       <= pct_pkg::ST_IDLE;
      total_q     <= pct_pkg::DefaultSecRst;
      remaining_q <= pct_pkg::DefaultSecRst;
      last_ms_q   <= '0;
      completed_q <= '0;
      flag_q      <= 1'b0;
      deadline_q  <= '0;
    end else if (fire) begin
      run_q       <= run_d;
      total_q     <= total_d;
      remaining_q <= remaining_d;
      last_ms_q   <= last_ms_d;
      completed_q <= completed_d;
      flag_q      <= flag_d;
      deadline_q  <= deadline_d;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance) begin
      out_vld_q <= in_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_run_q  <= pct_pkg::run_code(run_d);
      out_rem_q  <= remaining_d;
      out_tot_q  <= total_d;
      out_cnt_q  <= completed_d;
      out_flag_q <= flag_out;
    end
  end

  assign out_valid_o         = out_vld_q;
  assign run_state_o         = out_run_q;
  assign remaining_seconds_o = out_rem_q;
  assign total_seconds_o     = out_tot_q;
  assign completed_count_o   = out_cnt_q;
  assign tick_flag_o         = out_flag_q;

  // Session state stays one-hot
  a_run_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(run_q))
    else $error("session state not one-hot");

  // Completion count moves only by one, on entry to finished
  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && run_q != pct_pkg::ST_FINISHED && run_d == pct_pkg::ST_FINISHED)
    |=> (completed_q == $past(completed_q) + 8'd1))
    else $error("completion count did not advance on finish");

  // Session lengths hold while no item goes through
  a_hold_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !fire |=> ($stable(total_q) && $stable(remaining_q) && $stable(completed_q)))
    else $error("session state changed without an item");

  // A full input stage behind a stalled result must stall the input
  a_backpressure: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_vld_q && out_vld_q && out_stall_i) |-> in_stall_o)
    else $error("input not stalled behind a held result");

endmodule

// ===== test/tb_pausable_countdown_timer.sv =====
// Testbench for pausable_countdown_timer: directed rows, then random sessions
// under several register setups and pacing modes, checked beat by beat.
// Depends on pct_pkg and the timer RTL.
module tb_pausable_countdown_timer;

  // Request codes the block treats as no-ops
  localparam logic [pct_pkg::ReqW-1:0] REQ_NOP_A = 3'd6;
  localparam logic [pct_pkg::ReqW-1:0] REQ_NOP_B = 3'd7;

  localparam logic [pct_pkg::MsW-1:0] MsPerSec = 32'd1000;
  localparam logic [pct_pkg::SecW-1:0] SecMask = {pct_pkg::SecW{1'b1}};
  localparam int CycleLimit = 400000;
  localparam int ItemsPerPhase = 150;
  localparam int NumPhases = 6;

  typedef struct packed {
    logic [1:0]               rs;
    logic [pct_pkg::SecW-1:0] rem;
    logic [pct_pkg::SecW-1:0] tot;
    logic [pct_pkg::CntW-1:0] cnt;
    logic                     flag;
  } session_view_t;

  typedef struct packed {
    logic [pct_pkg::ReqW-1:0]   req;
    logic [pct_pkg::MsW-1:0]    ms;
    logic [pct_pkg::EpochW-1:0] ep;
    logic                       typed;
    session_view_t              view;
  } stim_row_t;

  typedef struct packed {
    logic [pct_pkg::CfgDataW-1:0] dflt;
    logic [pct_pkg::CfgDataW-1:0] max;
    logic [pct_pkg::CfgDataW-1:0] min;
    logic [pct_pkg::CfgDataW-1:0] floor;
  } timer_cfg_t;

  localparam session_view_t IdleAtReset =
    '{pct_pkg::RS_IDLE, 17'd1500, 17'd1500, 8'd0, 1'b0};
  localparam session_view_t NoView = '0;

  // Directed rows, run with the reset register values
  localparam int NumRows = 22;
  localparam stim_row_t StimRows [NumRows] = '{
    '{pct_pkg::REQ_CLEAR_FLAG, 32'd0, 40'd0, 1'b1, IdleAtReset},
    '{pct_pkg::REQ_TICK, 32'hFFFF_FFFF, 40'hFF_FFFF_FFFF, 1'b1, IdleAtReset},
    '{REQ_NOP_A, 32'hAAAA_AAAA, 40'h55_5555_5555, 1'b1, IdleAtReset},
    '{REQ_NOP_B, 32'h5555_5555, 40'hAA_AAAA_AAAA, 1'b1, IdleAtReset},
    '{pct_pkg::REQ_ADD_MIN, 32'd0, 40'd0, 1'b1,
      '{pct_pkg::RS_IDLE, 17'd1560, 17'd1560, 8'd0, 1'b0}},
    '{pct_pkg::REQ_SUB_MIN, 32'd0, 40'd0, 1'b1, IdleAtReset},
    '{pct_pkg::REQ_TOGGLE, 32'hFFFF_FC18, 40'd0, 1'b1,
      '{pct_pkg::RS_RUNNING, 17'd1500, 17'd1500, 8'd0, 1'b0}},
    // elapsed time wraps through zero: 3 s
    '{pct_pkg::REQ_TICK, 32'h0000_07D0, 40'd0, 1'b1,
      '{pct_pkg::RS_RUNNING, 17'd1497, 17'd1500, 8'd0, 1'b1}},
    '{pct_pkg::REQ_CLEAR_FLAG, 32'd0, 40'd0, 1'b1,
      '{pct_pkg::RS_RUNNING, 17'd1497, 17'd1500, 8'd0, 1'b1}},
    '{pct_pkg::REQ_CLEAR_FLAG, 32'd0, 40'd0, 1'b1,
      '{pct_pkg::RS_RUNNING, 17'd1497, 17'd1500, 8'd0, 1'b0}},
    '{pct_pkg::REQ_TOGGLE, 32'd0, 40'd0, 1'b1,
      '{pct_pkg::RS_PAUSED, 17'd1497, 17'd1500, 8'd0, 1'b0}},
    '{pct_pkg::REQ_TICK, 32'h0010_0000, 40'd0, 1'b1,
      '{pct_pkg::RS_PAUSED, 17'd1497, 17'd1500, 8'd0, 1'b0}},
    // resume on a trusted wall clock, count down by it, then pass the deadline
    '{pct_pkg::REQ_TOGGLE, 32'd5000, 40'd1700000100, 1'b0, NoView},
    '{pct_pkg::REQ_TICK, 32'd6000, 40'd1700000200, 1'b0, NoView},
    '{pct_pkg::REQ_TICK, 32'd7000, 40'd1700001597, 1'b0, NoView},
    '{pct_pkg::REQ_ADD_MIN, 32'd0, 40'd0, 1'b0, NoView},
    '{pct_pkg::REQ_TOGGLE, 32'd100, 40'd1699999999, 1'b0, NoView},
    '{pct_pkg::REQ_SUB_MIN, 32'd0, 40'd0, 1'b0, NoView},
    // almost a full wrap of the millisecond counter: expires at once
    '{pct_pkg::REQ_TICK, 32'd99, 40'd0, 1'b0, NoView},
    '{pct_pkg::REQ_TOGGLE, 32'd0, 40'd0, 1'b0, NoView},
    '{pct_pkg::REQ_TOGGLE, 32'd0, 40'd1700000000, 1'b0, NoView},
    '{pct_pkg::REQ_RESET, 32'd0, 40'd0, 1'b0, NoView}
  };

  // Register setups for the random phases; wide data checks the masking
  localparam timer_cfg_t Setups [4] = '{
    '{40'hFF_FFFE_0078, 40'd86400, 40'd60, 40'd0},
    '{40'd86400, 40'd131071, 40'd86400, 40'hFF_FFFF_FFFF},
    '{40'd60, 40'd60, 40'd0, 40'd1700000000},
    '{40'd1500, 40'd5400, 40'd60, 40'd1700000000}
  };
  localparam int TxIdlePct [3] = '{16, 77, 0};
  localparam int RxIdlePct [3] = '{77, 16, 0};

  logic clk = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [pct_pkg::ReqW-1:0] req_type_i = '0;
  logic [pct_pkg::MsW-1:0] now_ms_i = '0;
  logic [pct_pkg::EpochW-1:0] now_epoch_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic [1:0] run_state_o;
  logic [pct_pkg::SecW-1:0] remaining_seconds_o;
  logic [pct_pkg::SecW-1:0] total_seconds_o;
  logic [pct_pkg::CntW-1:0] completed_count_o;
  logic tick_flag_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [pct_pkg::CfgIdxW-1:0] cfg_index_i = '0;
  logic [pct_pkg::CfgDataW-1:0] cfg_data_i = '0;

  pausable_countdown_timer uut (
    .clk_i              (clk),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .req_type_i         (req_type_i),
    .now_ms_i           (now_ms_i),
    .now_epoch_i        (now_epoch_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .run_state_o        (run_state_o),
    .remaining_seconds_o(remaining_seconds_o),
    .total_seconds_o    (total_seconds_o),
    .completed_count_o  (completed_count_o),
    .tick_flag_o        (tick_flag_o),
    .cfg_valid_i        (cfg_valid_i),
    .cfg_ready_o        (cfg_ready_o),
    .cfg_index_i        (cfg_index_i),
    .cfg_data_i         (cfg_data_i)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Mirror of the registers and the session
  logic [pct_pkg::SecW-1:0]   cfg_default = pct_pkg::DefaultSecRst;
  logic [pct_pkg::SecW-1:0]   cfg_max     = pct_pkg::MaxSecRst;
  logic [pct_pkg::SecW-1:0]   cfg_min     = pct_pkg::MinSecRst;
  logic [pct_pkg::EpochW-1:0] cfg_floor   = pct_pkg::EpochFloorRst;
  logic [1:0]                 sess_state  = pct_pkg::RS_IDLE;
  logic [pct_pkg::SecW-1:0]   sess_rem    = pct_pkg::DefaultSecRst;
  logic [pct_pkg::SecW-1:0]   sess_tot    = pct_pkg::DefaultSecRst;
  logic [pct_pkg::MsW-1:0]    last_ms     = '0;
  logic [pct_pkg::CntW-1:0]   done_cnt    = '0;
  logic                       sess_flag   = 1'b0;
  logic [pct_pkg::DlW-1:0]    deadline    = '0;

  session_view_t expected_views [$];
  int errors = 0;
  int n_items = 0;
  int n_checked = 0;
  int n_expired = 0;
  int tx_idle_pct = TxIdlePct[0];
  int rx_idle_pct = RxIdlePct[0];
  int cycle_cnt = 0;
  int hold_left = 0;
  logic hold_arm = 1'b0;
  logic hold_done = 1'b0;

  // Put the session back to idle with the default length
  function automatic void reload_session();
    sess_state = pct_pkg::RS_IDLE;
    sess_tot = cfg_default;
    sess_rem = cfg_default;
    last_ms = '0;
  endfunction

  // Apply one request to the mirror and return the beat it should produce
  function automatic session_view_t advance_session(logic [pct_pkg::ReqW-1:0] req,
                                                    logic [pct_pkg::MsW-1:0] ms,
                                                    logic [pct_pkg::EpochW-1:0] ep);
    session_view_t v;
    logic [31:0] sum;
    logic [pct_pkg::MsW-1:0] elapsed;
    logic [pct_pkg::MsW-1:0] step;
    logic [pct_pkg::DlW-1:0] left;
    logic by_ms;
    case (req)
      pct_pkg::REQ_TOGGLE: begin
        case (sess_state)
          pct_pkg::RS_IDLE, pct_pkg::RS_PAUSED: begin
            sess_state = pct_pkg::RS_RUNNING;
            last_ms = ms;
            deadline = {1'b0, ep} + {{(pct_pkg::DlW-pct_pkg::SecW){1'b0}}, sess_rem};
          end
          pct_pkg::RS_RUNNING: sess_state = pct_pkg::RS_PAUSED;
          default: reload_session();
        endcase
      end
      pct_pkg::REQ_ADD_MIN: begin
        sum = 32'(sess_tot) + 32'(pct_pkg::SecPerMin);
        if (sum <= 32'(cfg_max) && sum <= 32'(SecMask)) begin
          sess_tot = sum[pct_pkg::SecW-1:0];
          if (sess_state == pct_pkg::RS_FINISHED) begin
            sess_state = pct_pkg::RS_IDLE;
            sess_rem = sess_tot;
          end else if (32'(sess_rem) + 32'(pct_pkg::SecPerMin) <= 32'(sess_tot)) begin
            sess_rem = sess_rem + pct_pkg::SecPerMin;
          end
        end
      end
      pct_pkg::REQ_SUB_MIN: begin
        if (sess_tot > cfg_min && sess_tot >= pct_pkg::SecPerMin) begin
          sess_tot = sess_tot - pct_pkg::SecPerMin;
          if (sess_rem > pct_pkg::SecPerMin) begin
            sess_rem = sess_rem - pct_pkg::SecPerMin;
          end else begin
            sess_rem = sess_tot;
            sess_state = pct_pkg::RS_IDLE;
          end
        end
      end
      pct_pkg::REQ_TICK: begin
        if (sess_state == pct_pkg::RS_RUNNING) begin
          by_ms = 1'b1;
          // trusted wall clock: count to the deadline, or drop to zero past it
          if (ep > cfg_floor && deadline > {1'b0, cfg_floor}) begin
            if ({1'b0, ep} < deadline) begin
              by_ms = 1'b0;
              left = deadline - {1'b0, ep};
              if (left < {{(pct_pkg::DlW-pct_pkg::SecW){1'b0}}, sess_rem}) begin
                sess_rem = left[pct_pkg::SecW-1:0];
                sess_flag = 1'b1;
              end
            end else begin
              sess_rem = '0;
            end
          end
          if (by_ms) begin
            elapsed = ms - last_ms;
            last_ms = ms;
            step = elapsed / MsPerSec;
            if ({{(pct_pkg::MsW-pct_pkg::SecW){1'b0}}, sess_rem} > step) begin
              sess_rem = sess_rem - step[pct_pkg::SecW-1:0];
            end else begin
              sess_rem = '0;
              sess_state = pct_pkg::RS_FINISHED;
              done_cnt = done_cnt + 1'b1;
              n_expired++;
            end
            sess_flag = 1'b1;
          end
        end
      end
      pct_pkg::REQ_RESET: reload_session();
      default: ;
    endcase
    v = '{sess_state, sess_rem, sess_tot, done_cnt, sess_flag};
    if (req == pct_pkg::REQ_CLEAR_FLAG) sess_flag = 1'b0;
    return v;
  endfunction

  // Offer one request after a random gap; record its expected beat on accept
  task automatic send_item(logic [pct_pkg::ReqW-1:0] req, logic [pct_pkg::MsW-1:0] ms,
                           logic [pct_pkg::EpochW-1:0] ep, logic typed,
                           session_view_t view);
    int gap;
    session_view_t predicted;
    gap = 0;
    while (gap < 30 && $urandom_range(0, 99) < tx_idle_pct) gap++;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid_i <= 1'b1;
    req_type_i <= req;
    now_ms_i <= ms;
    now_epoch_i <= ep;
    @(posedge clk);
    while (in_stall_o) @(posedge clk);
    predicted = advance_session(req, ms, ep);
    expected_views.push_back(typed ? view : predicted);
    n_items++;
  endtask

  // Drop valid, wait for every result, then let the pipeline go quiet
  task automatic settle_block(int quiet);
    in_valid_i <= 1'b0;
    while (expected_views.size() != 0) @(posedge clk);
    repeat (quiet) @(posedge clk);
  endtask

  // One register write beat; the mirror follows once it is taken
  task automatic cfg_beat(pct_pkg::cfg_idx_e idx, logic [pct_pkg::CfgDataW-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    @(posedge clk);
    while (!cfg_ready_o) @(posedge clk);
    case (idx)
      pct_pkg::CFG_DEFAULT_SEC: cfg_default = data[pct_pkg::SecW-1:0];
      pct_pkg::CFG_MAX_SEC:     cfg_max = data[pct_pkg::SecW-1:0];
      pct_pkg::CFG_MIN_SEC:     cfg_min = data[pct_pkg::SecW-1:0];
      default:                  cfg_floor = data[pct_pkg::EpochW-1:0];
    endcase
  endtask

  task automatic program_timer(timer_cfg_t c);
    cfg_beat(pct_pkg::CFG_DEFAULT_SEC, c.dflt);
    cfg_beat(pct_pkg::CFG_MAX_SEC, c.max);
    cfg_beat(pct_pkg::CFG_MIN_SEC, c.min);
    cfg_beat(pct_pkg::CFG_EPOCH_FLOOR, c.floor);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic note_field(string name, int unsigned want, int unsigned got);
    $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
    errors++;
  endtask

  // Receiver: random stall, plus one long hold-off when armed
  always @(posedge clk) begin
    if (hold_left != 0) begin
      out_stall_i <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_arm && !hold_done) begin
      out_stall_i <= 1'b1;
      hold_left <= 300;
      hold_done <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(0, 99) < rx_idle_pct);
    end
  end

  // Compare each result beat with the oldest expectation
  always @(posedge clk) begin
    session_view_t want;
    if (out_valid_o && !out_stall_i) begin
      if (expected_views.size() == 0) begin
        $display("%0t: result beat with nothing expected", $time);
        errors++;
      end else begin
        want = expected_views.pop_front();
        if (run_state_o !== want.rs) note_field("run_state", want.rs, run_state_o);
        if (remaining_seconds_o !== want.rem)
          note_field("remaining_seconds", want.rem, remaining_seconds_o);
        if (total_seconds_o !== want.tot)
          note_field("total_seconds", want.tot, total_seconds_o);
        if (completed_count_o !== want.cnt)
          note_field("completed_count", want.cnt, completed_count_o);
        if (tick_flag_o !== want.flag) note_field("tick_flag", want.flag, tick_flag_o);
        n_checked++;
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CycleLimit) begin
      $display("%0t: timeout with %0d results outstanding", $time, expected_views.size());
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    int mode;
    int r;
    logic [pct_pkg::ReqW-1:0] req;
    logic [pct_pkg::MsW-1:0] cur_ms;
    logic [pct_pkg::EpochW-1:0] cur_ep;
    logic [pct_pkg::EpochW-1:0] ep;
    int unsigned dt;
    repeat (10) @(posedge clk);
    rst_ni <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < NumRows; i++) begin
      send_item(StimRows[i].req, StimRows[i].ms, StimRows[i].ep,
                StimRows[i].typed, StimRows[i].view);
    end

    for (int ph = 0; ph < NumPhases; ph++) begin
      settle_block(4);
      program_timer(Setups[ph % 4 == 3 && ph > 3 ? 2 : ph % 4]);
      mode = ph / 2;
      tx_idle_pct = TxIdlePct[mode];
      rx_idle_pct <= RxIdlePct[mode];
      if (mode == 2) hold_arm <= 1'b1;
      cur_ms = $urandom();
      cur_ep = cfg_floor + 40'($urandom_range(1, 5000));

      for (int n = 0; n < ItemsPerPhase; n++) begin
        // mostly ticks and toggles so sessions run down and finish
        r = $urandom_range(0, 99);
        if (r < 40) req = pct_pkg::REQ_TICK;
        else if (r < 55) req = pct_pkg::REQ_TOGGLE;
        else if (r < 65) req = pct_pkg::REQ_ADD_MIN;
        else if (r < 75) req = pct_pkg::REQ_SUB_MIN;
        else if (r < 80) req = pct_pkg::REQ_RESET;
        else if (r < 92) req = pct_pkg::REQ_CLEAR_FLAG;
        else if (r < 96) req = REQ_NOP_A;
        else req = REQ_NOP_B;

        // advance both clocks together, with the odd jump and stray value
        if ($urandom_range(0, 99) < 5) begin
          cur_ms = $urandom();
        end else begin
          dt = $urandom_range(0, 120000);
          cur_ms = cur_ms + dt;
          cur_ep = cur_ep + 40'(dt / 1000);
          if ($urandom_range(0, 9) == 0) cur_ep = cur_ep + 40'($urandom_range(0, 5));
        end
        r = $urandom_range(0, 99);
        if (r < 8) ep = {8'($urandom_range(0, 255)), 32'($urandom())};
        else if (r < 14) ep = 40'($urandom_range(0, 100000));
        else ep = cur_ep;

        send_item(req, cur_ms, ep, 1'b0, NoView);
      end
    end

    settle_block(8);
    $display("Sent %0d requests (%0d directed) across %0d register setups and 3 pacing modes;",
             n_items, NumRows, NumPhases);
    $display("checked %0d results, %0d sessions ran out.", n_checked, n_expired);
    if (expected_views.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, expected_views.size());
      errors++;
    end
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ===== files.f =====
sv/pct_pkg.sv
sv/pausable_countdown_timer.sv
test/tb_pausable_countdown_timer.sv
